[sv/sdaq_pkg.sv]
// ----------------------------------------------------------------------------
// sdaq_pkg
// Types and constants shared by the sorted deadline alarm queue.
// ----------------------------------------------------------------------------
package sdaq_pkg;

	localparam int DEPTH       = 16;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int MAX_RESULTS = 16;
	localparam int FIRE_W      = $clog2(MAX_RESULTS + 1);
	localparam int CMDQ_DEPTH  = 2;
	localparam int CMDQ_IDX_W  = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W  = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH  = 2;
	localparam int OUTQ_IDX_W  = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
	localparam int US_PER_MS   = 1000;
	// ceil(2^36 / 1000): exact floor divide by 1000 for numerators below 2^26
	localparam logic [26:0] MS_RECIP = 27'd68719477;
	localparam int MS_SHIFT    = 36;
	localparam logic [31:0] DELAY_MAX = 32'h7fff_ffff;

	typedef enum logic [2:0] {
		CMD_ARM    = 3'd0,
		CMD_CANCEL = 3'd1,
		CMD_POLL   = 3'd2,
		CMD_DLY_US = 3'd3,
		CMD_DLY_MS = 3'd4
	} cmd_e_t;

	typedef enum logic [2:0] {
		KIND_ARMED     = 3'd0,
		KIND_FULL      = 3'd1,
		KIND_CANCELLED = 3'd2,
		KIND_NOT_FOUND = 3'd3,
		KIND_FIRED     = 3'd4,
		KIND_NONE_DUE  = 3'd5,
		KIND_DELAY     = 3'd6
	} kind_e_t;

	// classified command travelling from front to back
	typedef struct packed {
		cmd_e_t      cmd;
		logic [62:0] deadline;
		logic [62:0] now;
		logic [31:0] id;
		logic [31:0] tag;
	} job_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] id;
		logic [31:0] tag;
		logic [31:0] delay;
		logic        last;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ARM_SCAN,
		ST_ARM_SHIFT,
		ST_CAN_SCAN,
		ST_DEL_SHIFT,
		ST_POLL_CHK,
		ST_DLY,
		ST_DIV,
		ST_DIV_REM,
		ST_MUL,
		ST_EMIT
	} state_t;

endpackage

[sv/sdaq_front.sv]
// ----------------------------------------------------------------------------
// sdaq_front
// Accepts items, drops unknown commands and queues the rest for the engine.
// ----------------------------------------------------------------------------
module sdaq_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [2:0]      cmd,
	input  logic [62:0]     deadline_us,
	input  logic [62:0]     now_us,
	input  logic [31:0]     cancel_id,
	input  logic [31:0]     user_tag,
	output logic            job_valid,
	input  logic            job_take,
	output sdaq_pkg::job_t  job
);
	import sdaq_pkg::*;

	job_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_IDX_W-1:0] wr_q, rd_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  known, wr_en, rd_en;

	assign known = (cmd <= 3'(CMD_DLY_MS));
	assign full  = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign wr_en = push && !full && known;
	assign rd_en = job_valid && job_take;
	assign job_valid = (cnt_q != '0);
	assign job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= '{cmd: cmd_e_t'(cmd), deadline: deadline_us, now: now_us,
				id: cancel_id, tag: user_tag};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= (wr_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (rd_en)
				rd_q <= (rd_q == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CMDQ_CNT_W'(wr_en) - CMDQ_CNT_W'(rd_en);
		end
	end

endmodule

[sv/sdaq_back.sv]
// ----------------------------------------------------------------------------
// sdaq_back
// Sorted alarm table with a sequencer that walks it one slot a cycle.
// ----------------------------------------------------------------------------
module sdaq_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_take,
	input  sdaq_pkg::job_t  job,
	output logic            res_valid,
	input  logic            res_room,
	output sdaq_pkg::res_t  res
);
	import sdaq_pkg::*;

	logic [62:0] dl_q  [DEPTH];
	logic [31:0] id_q  [DEPTH];
	logic [31:0] tag_q [DEPTH];

	state_t          st_q, st_d;
	job_t            job_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]     next_id_q;
	logic [CNT_W-1:0] pos_q;
	logic [FIRE_W-1:0] fired_q;
	res_t            res_q;
	logic            ret_poll_q;
	logic [62:0]     diff_q, quo_q;
	logic [9:0]      rem_q;
	logic [15:0]     qd_q;
	logic [1:0]      div_i_q;

	logic [IDX_W-1:0] pidx, pidx1;
	logic [31:0]      id_base, id_new;
	logic             head_due, pos_end;
	logic             fire, more;
	logic [15:0]      dchunk;
	logic [25:0]      dnum;
	logic [52:0]      dprod;
	logic [62:0]      ms_sat;

	assign pidx    = pos_q[IDX_W-1:0];
	assign pidx1   = IDX_W'(pos_q + 1'b1);
	assign pos_end = (pos_q >= count_q);
	assign id_base = (next_id_q == '0) ? 32'd1 : next_id_q;
	assign id_new  = id_base + 32'd1;
	assign head_due = (count_q != '0) && (dl_q[0] <= job_q.now);
	assign fire    = (fired_q < FIRE_W'(MAX_RESULTS)) && head_due;
	// another alarm will still be due after this one leaves
	assign more    = (FIRE_W'(fired_q + 1'b1) < FIRE_W'(MAX_RESULTS)) &&
		(count_q > CNT_W'(1)) && (dl_q[1] <= job_q.now);
	assign dnum    = {rem_q, dchunk};
	assign dprod   = 53'(dnum) * 53'(MS_RECIP);
	assign ms_sat  = (quo_q > 63'(DELAY_MAX)) ? 63'(DELAY_MAX) : quo_q;

	// divide by 1000 in 16-bit digits, most significant first
	always_comb begin
		unique case (div_i_q)
			2'd0:    dchunk = {1'b0, diff_q[62:48]};
			2'd1:    dchunk = diff_q[47:32];
			2'd2:    dchunk = diff_q[31:16];
			default: dchunk = diff_q[15:0];
		endcase
	end

	assign job_take  = (st_q == ST_IDLE) && job_valid;
	assign res_valid = (st_q == ST_EMIT);
	assign res       = res_q;

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: begin
				if (job_valid) begin
					unique case (job.cmd)
						CMD_ARM:    st_d = ST_ARM_SCAN;
						CMD_CANCEL: st_d = ST_CAN_SCAN;
						CMD_POLL:   st_d = ST_POLL_CHK;
						default:    st_d = ST_DLY;
					endcase
				end
			end
			ST_ARM_SCAN: begin
				if (count_q == CNT_W'(DEPTH))
					st_d = ST_EMIT;
				else if (pos_end || job_q.deadline < dl_q[pidx])
					st_d = ST_ARM_SHIFT;
			end
			ST_ARM_SHIFT: st_d = ST_EMIT;
			ST_CAN_SCAN: begin
				if (pos_end)
					st_d = ST_EMIT;
				else if (id_q[pidx] == job_q.id)
					st_d = ST_DEL_SHIFT;
			end
			ST_DEL_SHIFT: if (pos_q + 1'b1 >= count_q) st_d = ST_EMIT;
			ST_POLL_CHK: st_d = ST_EMIT;
			ST_DLY: begin
				if (count_q != '0 && !head_due && job_q.cmd == CMD_DLY_MS)
					st_d = ST_DIV;
				else
					st_d = ST_EMIT;
			end
			ST_DIV: st_d = ST_DIV_REM;
			ST_DIV_REM: st_d = (div_i_q == 2'd3) ? ST_MUL : ST_DIV;
			ST_MUL: st_d = ST_EMIT;
			ST_EMIT: begin
				if (res_room)
					st_d = ret_poll_q ? ST_POLL_CHK : ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q   <= job;
				pos_q   <= '0;
				fired_q <= '0;
				div_i_q <= '0;
				rem_q   <= '0;
				quo_q   <= '0;
				diff_q  <= dl_q[0] - job.now;
			end
			ST_ARM_SCAN: begin
				if (count_q == CNT_W'(DEPTH))
					res_q <= '{kind: KIND_FULL, id: '0, tag: '0, delay: '0, last: 1'b1};
				else if (!(pos_end || job_q.deadline < dl_q[pidx]))
					pos_q <= pos_q + 1'b1;
			end
			ST_ARM_SHIFT: begin
				for (int i = 1; i < DEPTH; i++) begin
					if (CNT_W'(i) > pos_q && CNT_W'(i) <= count_q) begin
						dl_q[i]  <= dl_q[i-1];
						id_q[i]  <= id_q[i-1];
						tag_q[i] <= tag_q[i-1];
					end
				end
				dl_q[pidx]  <= job_q.deadline;
				id_q[pidx]  <= id_base;
				tag_q[pidx] <= job_q.tag;
				res_q <= '{kind: KIND_ARMED, id: id_base, tag: '0, delay: '0, last: 1'b1};
			end
			ST_CAN_SCAN: begin
				if (pos_end)
					res_q <= '{kind: KIND_NOT_FOUND, id: '0, tag: '0, delay: '0, last: 1'b1};
				else if (id_q[pidx] != job_q.id)
					pos_q <= pos_q + 1'b1;
			end
			ST_DEL_SHIFT: begin
				// one slot closes up per cycle; count is already one down here
				if (pos_q < count_q) begin
					dl_q[pidx]  <= dl_q[pidx1];
					id_q[pidx]  <= id_q[pidx1];
					tag_q[pidx] <= tag_q[pidx1];
					pos_q <= pos_q + 1'b1;
				end
				if (job_q.cmd == CMD_CANCEL)
					res_q <= '{kind: KIND_CANCELLED, id: job_q.id, tag: '0, delay: '0,
						last: 1'b1};
			end
			ST_POLL_CHK: begin
				if (fire) begin
					res_q <= '{kind: KIND_FIRED, id: id_q[0], tag: tag_q[0], delay: '0,
						last: !more};
					fired_q <= fired_q + 1'b1;
					// remove the head: shift the whole table down by one
					for (int i = 0; i < DEPTH - 1; i++) begin
						dl_q[i]  <= dl_q[i+1];
						id_q[i]  <= id_q[i+1];
						tag_q[i] <= tag_q[i+1];
					end
				end else if (fired_q == '0) begin
					res_q <= '{kind: KIND_NONE_DUE, id: '0, tag: '0, delay: '0, last: 1'b1};
				end
			end
			ST_DLY: begin
				res_q.kind <= KIND_DELAY;
				res_q.id   <= '0;
				res_q.tag  <= '0;
				res_q.last <= 1'b1;
				if (count_q == '0)
					res_q.delay <= 32'hffff_ffff;
				else if (head_due)
					res_q.delay <= '0;
				else if (diff_q > 63'(DELAY_MAX))
					res_q.delay <= DELAY_MAX;
				else
					res_q.delay <= diff_q[31:0];
			end
			ST_DIV: begin
				// quotient digit by reciprocal multiply
				qd_q <= dprod[MS_SHIFT +: 16];
			end
			ST_DIV_REM: begin
				rem_q   <= 10'(dnum - 26'(qd_q) * 26'(US_PER_MS));
				quo_q   <= {quo_q[46:0], qd_q};
				div_i_q <= div_i_q + 1'b1;
			end
			ST_MUL: begin
				res_q.delay <= ms_sat[31:0];
				dl_q[0] <= job_q.now + 63'(ms_sat[31:0] * 42'(US_PER_MS));
			end
			ST_EMIT: begin
				pos_q <= '0;
			end
			default: ;
		endcase
	end

	// poll: after a fire that leaves more due, come back for the next head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_poll_q <= 1'b0;
		end else if (st_q == ST_POLL_CHK) begin
			ret_poll_q <= fire && more;
		end else if (st_q == ST_EMIT && res_room) begin
			ret_poll_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			count_q   <= '0;
			next_id_q <= '0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_ARM_SHIFT) begin
				count_q   <= count_q + 1'b1;
				next_id_q <= id_new;
			end
			if (st_q == ST_CAN_SCAN && !pos_end && id_q[pidx] == job_q.id)
				count_q <= count_q - 1'b1;
			if (st_q == ST_POLL_CHK && fire)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

[sv/sdaq_outq.sv]
// ----------------------------------------------------------------------------
// sdaq_outq
// Small result queue presented on the pop side.
// ----------------------------------------------------------------------------
module sdaq_outq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_valid,
	output logic            res_room,
	input  sdaq_pkg::res_t  res_in,
	input  logic            pop,
	output logic            empty,
	output sdaq_pkg::res_t  res_out
);
	import sdaq_pkg::*;

	res_t                  mem_q [OUTQ_DEPTH];
	logic [OUTQ_IDX_W-1:0] wr_q, rd_q;
	logic [OUTQ_CNT_W-1:0] cnt_q;
	logic                  wr_en, rd_en;

	assign res_room = (cnt_q != OUTQ_CNT_W'(OUTQ_DEPTH));
	assign empty    = (cnt_q == '0);
	assign wr_en    = res_valid && res_room;
	assign rd_en    = pop && !empty;
	assign res_out  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_q] <= res_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en)
				wr_q <= (wr_q == OUTQ_IDX_W'(OUTQ_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (rd_en)
				rd_q <= (rd_q == OUTQ_IDX_W'(OUTQ_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + OUTQ_CNT_W'(wr_en) - OUTQ_CNT_W'(rd_en);
		end
	end

endmodule

[sv/sorted_deadline_alarm_queue.sv]
// ----------------------------------------------------------------------------
// sorted_deadline_alarm_queue
// Deadline-sorted alarm table with arm, cancel, poll and delay queries.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue interface (push/full); results leave
//   through a queue interface (empty/pop), oldest first, with last set on
//   the final result of each command. Unknown commands are dropped silently.
//   A front command queue of two entries decouples the input from the
//   engine; a two-entry result queue decouples the engine from the reader.
//   Arm scans the table one slot a cycle for its place, then shifts the
//   later entries up (or answers full when the table is full); cancel
//   scans, then closes up one slot a cycle; poll gives one result per
//   fired alarm; delay in ms divides by 1000 in four 16-bit digits unless
//   the table is empty or the head is already due.
//   One command is worked on at a time by the sequencer in the back end,
//   which passes through its idle state between commands.
//   Reset empties the table and both queues and restarts ids at 1.
//   When the reader stalls, the result queue fills, the engine holds its
//   result and stops, and the command queue then raises full.
// ----------------------------------------------------------------------------
module sorted_deadline_alarm_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [62:0] deadline_us,
	input  logic [62:0] now_us,
	input  logic [31:0] cancel_id,
	input  logic [31:0] user_tag,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [31:0] result_id,
	output logic [31:0] result_tag,
	output logic signed [31:0] delay,
	output logic        last
);
	import sdaq_pkg::*;

	logic job_valid, job_take, res_valid, res_room;
	job_t job;
	res_t res_b, res_o;

	sdaq_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .deadline_us, .now_us, .cancel_id,
		.user_tag, .job_valid, .job_take, .job
	);

	sdaq_back u_back (
		.clk, .arst_n, .job_valid, .job_take, .job, .res_valid, .res_room,
		.res(res_b)
	);

	sdaq_outq u_outq (
		.clk, .arst_n, .res_valid, .res_room, .res_in(res_b), .pop, .empty,
		.res_out(res_o)
	);

	assign kind       = res_o.kind;
	assign result_id  = res_o.id;
	assign result_tag = res_o.tag;
	assign delay      = signed'(res_o.delay);
	assign last       = res_o.last;

`ifndef NO_ASSERTIONS
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_take |-> job_valid) else $error("engine took from empty command queue");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_room |=> res_valid && $stable(res_b))
		else $error("engine result changed while stalled");
	a_fire_kind: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_b.kind == 3'(KIND_FIRED) |-> res_b.id != '0)
		else $error("fired alarm with id zero");
`endif

endmodule
